// ===== sv/scp_pkg.sv =====
// scp_pkg: types, character codes and reply tables shared by the serial CAN command parser.
// No dependencies; every parser module refers to it by scoped names.
package scp_pkg;

   typedef enum logic [2:0] {
      CMD_ACK,
      CMD_FRAME,
      CMD_FLAGS,
      CMD_VERSION,
      CMD_ERROR
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [11:0] id;
      logic [3:0]  len;
      logic [63:0] data;
      logic [7:0]  eflags;
   } job_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int STEP_W      = 3;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_BEL  = 8'h07;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_O    = 8'h4F;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_T    = 8'h74;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam logic [7:0] CHAR_V    = 8'h56;

   localparam logic [3:0] MAX_DATA = 4'd8;

   localparam int ID_FIRST   = 1;
   localparam int ID_LAST    = 3;
   localparam int LEN_POS    = 4;
   localparam int DATA_FIRST = 5;
   localparam int DATA_LAST  = 20;

   // {valid, digit}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = {4'h3, d};
      end else begin
         r = 8'h37 + {4'h0, d};
      end
      return r;
   endfunction

   // {last, reply byte} for one step of a command
   function automatic logic [8:0] reply_word(input cmd_type cmd, input logic [STEP_W-1:0] step,
                                            input logic [7:0] eflags);
      logic [8:0] r;
      r = {1'b1, CHAR_CR};
      case (cmd)
         CMD_ACK: begin
            r = {1'b1, CHAR_CR};
         end
         CMD_FRAME: begin
            r = (step == 3'd0) ? {1'b0, 8'h00} : {1'b1, CHAR_CR};
         end
         CMD_FLAGS: begin
            case (step)
               3'd0:    r = {1'b0, CHAR_F};
               3'd1:    r = {1'b0, hex_char(eflags[7:4])};
               3'd2:    r = {1'b0, hex_char(eflags[3:0])};
               default: r = {1'b1, CHAR_CR};
            endcase
         end
         CMD_VERSION: begin
            case (step)
               3'd0:    r = {1'b0, CHAR_V};
               3'd1:    r = {1'b0, CHAR_ZERO};
               3'd2:    r = {1'b0, CHAR_ONE};
               3'd3:    r = {1'b0, CHAR_ZERO};
               3'd4:    r = {1'b0, CHAR_ONE};
               default: r = {1'b1, CHAR_CR};
            endcase
         end
         default: begin
            r = {1'b1, CHAR_BEL};
         end
      endcase
      return r;
   endfunction

endpackage

// ===== sv/scp_front.sv =====
// scp_front: takes received characters, parses the line as it fills, classifies it at line end.
// Depends on scp_pkg; pushes one job_type per decoded line into the queue.
module scp_front #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_rx_byte,
   input  logic [7:0]      req_error_flags,
   input  logic            queue_full,
   output logic            push,
   output scp_pkg::job_type push_entry
);

   localparam int CW = $clog2(LINE_CAPACITY);
   localparam logic [CW-1:0] LIMIT = CW'(LINE_CAPACITY - 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    first_ff, first_in;
   logic [11:0]   id_ff, id_in;
   logic          id_stop_ff, id_stop_in;
   logic [3:0]    flen_ff, flen_in;
   logic [63:0]   data_ff, data_in;
   logic          dstop_ff, dstop_in;
   logic          open_ff, open_in;

   logic          take;
   logic          line_end;
   logic [4:0]    hx;
   logic [7:0]    lenv;
   logic [CW-1:0] off;
   logic [2:0]    bidx;
   logic [63:0]   data_masked;
   scp_pkg::cmd_type cmd;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;
   assign line_end  = (req_rx_byte == scp_pkg::CHAR_CR) || (req_rx_byte == scp_pkg::CHAR_LF);
   assign hx        = scp_pkg::hex_decode(req_rx_byte);
   assign lenv      = req_rx_byte - scp_pkg::CHAR_ZERO;
   assign off       = cnt_ff - CW'(scp_pkg::DATA_FIRST);
   assign bidx      = off[3:1];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         data_masked[8*k +: 8] = (4'(k) < flen_ff) ? data_ff[8*k +: 8] : 8'h00;
      end
   end

   always_comb begin
      case (first_ff)
         scp_pkg::CHAR_S: cmd = scp_pkg::CMD_ACK;
         scp_pkg::CHAR_O: cmd = scp_pkg::CMD_ACK;
         scp_pkg::CHAR_C: cmd = scp_pkg::CMD_ACK;
         scp_pkg::CHAR_T: cmd = open_ff ? scp_pkg::CMD_FRAME : scp_pkg::CMD_ERROR;
         scp_pkg::CHAR_F: cmd = scp_pkg::CMD_FLAGS;
         scp_pkg::CHAR_V: cmd = scp_pkg::CMD_VERSION;
         default:         cmd = scp_pkg::CMD_ERROR;
      endcase
   end

   assign push              = take && line_end && (cnt_ff != '0);
   assign push_entry.cmd    = cmd;
   assign push_entry.id     = id_ff;
   assign push_entry.len    = flen_ff;
   assign push_entry.data   = data_masked;
   assign push_entry.eflags = req_error_flags;

   always_comb begin
      cnt_in     = cnt_ff;
      first_in   = first_ff;
      id_in      = id_ff;
      id_stop_in = id_stop_ff;
      flen_in    = flen_ff;
      data_in    = data_ff;
      dstop_in   = dstop_ff;
      open_in    = open_ff;
      if (take && line_end) begin
         if (cnt_ff != '0) begin
            if (first_ff == scp_pkg::CHAR_O) begin
               open_in = 1'b1;
            end else if (first_ff == scp_pkg::CHAR_C) begin
               open_in = 1'b0;
            end
            cnt_in     = '0;
            first_in   = 8'h00;
            id_in      = 12'h000;
            id_stop_in = 1'b0;
            flen_in    = scp_pkg::MAX_DATA;
            data_in    = 64'h0;
            dstop_in   = 1'b0;
         end
      end else if (take && cnt_ff < LIMIT) begin
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == '0) begin
            first_in = req_rx_byte;
         end else if (cnt_ff >= CW'(scp_pkg::ID_FIRST) && cnt_ff <= CW'(scp_pkg::ID_LAST)) begin
            if (!id_stop_ff && hx[4]) begin
               id_in = {id_ff[7:0], hx[3:0]};
            end else begin
               id_stop_in = 1'b1;
            end
         end else if (cnt_ff == CW'(scp_pkg::LEN_POS)) begin
            flen_in = (lenv > 8'(scp_pkg::MAX_DATA)) ? scp_pkg::MAX_DATA : lenv[3:0];
         end else if (cnt_ff >= CW'(scp_pkg::DATA_FIRST)
                      && cnt_ff <= CW'(scp_pkg::DATA_LAST)) begin
            if (!off[0]) begin
               data_in[8*bidx +: 8] = hx[4] ? {4'h0, hx[3:0]} : 8'h00;
               dstop_in             = !hx[4];
            end else if (!dstop_ff && hx[4]) begin
               data_in[8*bidx +: 8] = {data_ff[8*bidx +: 4], hx[3:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         first_ff   <= 8'h00;
         id_ff      <= 12'h000;
         id_stop_ff <= 1'b0;
         flen_ff    <= scp_pkg::MAX_DATA;
         data_ff    <= 64'h0;
         dstop_ff   <= 1'b0;
         open_ff    <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         first_ff   <= first_in;
         id_ff      <= id_in;
         id_stop_ff <= id_stop_in;
         flen_ff    <= flen_in;
         data_ff    <= data_in;
         dstop_ff   <= dstop_in;
         open_ff    <= open_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= LIMIT)
      else $error("line count past capacity");
   a_flen_bound: assert property (@(posedge clock) disable iff (reset)
      flen_ff <= scp_pkg::MAX_DATA)
      else $error("frame length past eight");

endmodule

// ===== sv/scp_queue.sv =====
// scp_queue: short job queue between the line classifier and the reply sequencer.
// Depends on scp_pkg for job_type and QUEUE_DEPTH.
module scp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scp_pkg::job_type push_entry,
   output logic             full,
   input  logic             pop,
   output scp_pkg::job_type pop_entry,
   output logic             empty
);

   localparam int DEPTH = scp_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   scp_pkg::job_type slots [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [NW-1:0] num_ff, num_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full      = (num_ff == NW'(DEPTH));
   assign empty     = (num_ff == '0);
   assign pop_entry = slots[rd_ff];

   always_comb begin
      wr_in  = push ? next_ptr(wr_ff) : wr_ff;
      rd_in  = pop ? next_ptr(rd_ff) : rd_ff;
      num_in = num_ff;
      if (push && !pop) begin
         num_in = num_ff + NW'(1);
      end else if (pop && !push) begin
         num_in = num_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ===== sv/scp_back.sv =====
// scp_back: steps through each queued job and sends its reply words and CAN frame.
// Depends on scp_pkg for job_type, command codes and the reply tables.
module scp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  scp_pkg::job_type pop_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_reply_byte,
   output logic [11:0]      rsp_frame_id,
   output logic [3:0]       rsp_frame_length,
   output logic [63:0]      rsp_frame_data,
   output logic             rsp_last_of_run
);

   logic                       busy_ff, busy_in;
   scp_pkg::job_type           job_ff, job_in;
   logic [scp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       valid_ff, valid_in;
   logic                       kind_ff, kind_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [11:0]                id_ff, id_in;
   logic [3:0]                 len_ff, len_in;
   logic [63:0]                data_ff, data_in;
   logic                       last_ff, last_in;

   logic       load;
   logic       is_frame;
   logic [8:0] word;

   assign pop      = !busy_ff && !queue_empty;
   assign load     = busy_ff && (!valid_ff || rsp_ready);
   assign is_frame = (job_ff.cmd == scp_pkg::CMD_FRAME) && (step_ff == '0);
   assign word     = scp_pkg::reply_word(job_ff.cmd, step_ff, job_ff.eflags);

   always_comb begin
      busy_in  = busy_ff;
      job_in   = job_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (pop) begin
         busy_in = 1'b1;
         job_in  = pop_entry;
         step_in = '0;
      end
      if (load) begin
         valid_in = 1'b1;
         kind_in  = is_frame;
         byte_in  = is_frame ? 8'h00 : word[7:0];
         id_in    = is_frame ? job_ff.id : 12'h000;
         len_in   = is_frame ? job_ff.len : 4'h0;
         data_in  = is_frame ? job_ff.data : 64'h0;
         last_in  = word[8];
         step_in  = step_ff + scp_pkg::STEP_W'(1);
         busy_in  = !word[8];
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      step_ff <= step_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      id_ff   <= id_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_reply_byte   = byte_ff;
   assign rsp_frame_id     = id_ff;
   assign rsp_frame_length = len_ff;
   assign rsp_frame_data   = data_ff;
   assign rsp_last_of_run  = last_ff;

   a_frame_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff |-> !last_ff)
      else $error("frame word marked last");
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !kind_ff |-> (id_ff == 12'h000) && (len_ff == 4'h0) && (data_ff == 64'h0))
      else $error("reply word carries frame fields");

endmodule

// ===== sv/slcan_command_parser.sv =====
// slcan_command_parser: ASCII CAN adapter command parser, top level.
// Depends on scp_pkg, scp_front, scp_queue and scp_back.
//
//   channel   ports                      direction  word
//   req       req_valid/req_ready        in         received char + error flags
//   rsp       rsp_valid/rsp_ready        out        reply byte or CAN frame
//
// One character is taken per cycle while the job queue has room; line parsing is
// done as characters arrive, so the line is classified as its end is taken.
// The back part sends one word per cycle while rsp_ready is high: 1 (S/O/C/error),
// 2 (t), 4 (F) or 6 (V) words per line, then it fetches the next job from the queue.
// Synchronous reset clears the line, closes the channel and empties the queue.
// A stalled rsp side fills the queue, after which req_ready drops.
module slcan_command_parser #(
   parameter int LINE_CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_error_flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_reply_byte,
   output logic [11:0] rsp_frame_id,
   output logic [3:0]  rsp_frame_length,
   output logic [63:0] rsp_frame_data,
   output logic        rsp_last_of_run
);

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   scp_pkg::job_type push_entry;
   scp_pkg::job_type pop_entry;

   scp_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .req_error_flags(req_error_flags),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   scp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .pop_entry (pop_entry),
      .empty     (queue_empty)
   );

   scp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== tb/tb_slcan_command_parser.sv =====
// tb_slcan_command_parser: self-checking bench for the serial CAN command parser.
// Drives characters over req_, checks reply and frame words on rsp_ against a local line decoder.
// Depends on scp_pkg and slcan_command_parser.
module tb_slcan_command_parser;

   localparam int LINE_CAPACITY = 32;
   localparam int RANDOM_ITEMS  = 320;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;
   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;
   localparam logic [7:0] CMD_CHARS [6] = '{
      scp_pkg::CHAR_S, scp_pkg::CHAR_O, scp_pkg::CHAR_C,
      scp_pkg::CHAR_F, scp_pkg::CHAR_V, scp_pkg::CHAR_T
   };

   typedef struct {
      logic        kind;
      logic [7:0]  reply;
      logic [11:0] id;
      logic [3:0]  len;
      logic [63:0] data;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] ef;
      logic       fixed;
      logic [7:0] want;
   } char_row_type;

   localparam char_row_type DIR_ROWS [30] = '{
      '{"t",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b1, scp_pkg::CHAR_BEL},
      '{scp_pkg::CHAR_LF, 8'h00, 1'b0, 8'h00},
      '{"O",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b1, scp_pkg::CHAR_CR},
      '{"t",              8'h00, 1'b0, 8'h00},
      '{"f",              8'h00, 1'b0, 8'h00},
      '{"F",              8'h00, 1'b0, 8'h00},
      '{"a",              8'h00, 1'b0, 8'h00},
      '{"9",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_LF, 8'h00, 1'b0, 8'h00},
      '{"t",              8'h00, 1'b0, 8'h00},
      '{"1",              8'h00, 1'b0, 8'h00},
      '{"g",              8'h00, 1'b0, 8'h00},
      '{"/",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b0, 8'h00},
      '{"F",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'hFF, 1'b0, 8'h00},
      '{"F",              8'hFF, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b0, 8'h00},
      '{"V",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_LF, 8'h00, 1'b0, 8'h00},
      '{"C",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b1, scp_pkg::CHAR_CR},
      '{8'h00,            8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b1, scp_pkg::CHAR_BEL},
      '{8'hFF,            8'hFF, 1'b0, 8'h00},
      '{scp_pkg::CHAR_LF, 8'h00, 1'b1, scp_pkg::CHAR_BEL},
      '{"S",              8'h00, 1'b0, 8'h00},
      '{scp_pkg::CHAR_CR, 8'h00, 1'b1, scp_pkg::CHAR_CR}
   };

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte     = 8'h00;
   logic [7:0]  req_error_flags = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_reply_byte;
   logic [11:0] rsp_frame_id;
   logic [3:0]  rsp_frame_length;
   logic [63:0] rsp_frame_data;
   logic        rsp_last_of_run;

   logic [7:0]   line_buf [LINE_CAPACITY];
   int           line_len;
   logic         chan_open;
   rsp_word_type new_words [$];
   rsp_word_type pending_words [$];
   logic         calm = 1'b0;
   int           err_count = 0;
   int           stall_cycles = 0;

   slcan_command_parser #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_error_flags (req_error_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_frame_length(rsp_frame_length),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] line_char(int pos);
      return (pos < line_len) ? line_buf[pos] : 8'h00;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic logic [31:0] parse_hex(int start, int count);
      logic [31:0] v;
      int          d;
      v = 32'd0;
      for (int i = 0; i < count; i++) begin
         d = hex_digit(line_char(start + i));
         if (d < 0) break;
         v = (v << 4) | 32'(d);
      end
      return v;
   endfunction

   function automatic logic [7:0] hex_upper(logic [3:0] d);
      return (d < 4'd10) ? 8'("0" + d) : 8'("A" + d - 10);
   endfunction

   function automatic void queue_word(logic kind, logic [7:0] reply, logic [11:0] id,
                                      logic [3:0] len, logic [63:0] data);
      rsp_word_type w;
      w.kind  = kind;
      w.reply = reply;
      w.id    = id;
      w.len   = len;
      w.data  = data;
      w.last  = 1'b0;
      new_words.push_back(w);
   endfunction

   function automatic void parse_char(logic [7:0] ch, logic [7:0] ef);
      logic [7:0]  first;
      logic [7:0]  n;
      logic [63:0] data;
      new_words.delete();
      if (ch == scp_pkg::CHAR_CR || ch == scp_pkg::CHAR_LF) begin
         if (line_len > 0) begin
            first = line_char(0);
            if (first == scp_pkg::CHAR_S) begin
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else if (first == scp_pkg::CHAR_O) begin
               chan_open = 1'b1;
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else if (first == scp_pkg::CHAR_C) begin
               chan_open = 1'b0;
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else if (first == scp_pkg::CHAR_T && chan_open) begin
               n = line_char(scp_pkg::LEN_POS) - scp_pkg::CHAR_ZERO;
               if (n > {4'h0, scp_pkg::MAX_DATA}) n = {4'h0, scp_pkg::MAX_DATA};
               data = 64'd0;
               for (int i = 0; i < int'(n); i++) begin
                  data[8*i +: 8] = 8'(parse_hex(scp_pkg::DATA_FIRST + 2 * i, 2));
               end
               queue_word(KIND_FRAME, 8'h00, 12'(parse_hex(scp_pkg::ID_FIRST, 3)),
                          n[3:0], data);
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else if (first == scp_pkg::CHAR_F) begin
               queue_word(KIND_REPLY, scp_pkg::CHAR_F, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, hex_upper(ef[7:4]), 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, hex_upper(ef[3:0]), 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else if (first == scp_pkg::CHAR_V) begin
               queue_word(KIND_REPLY, scp_pkg::CHAR_V, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_ZERO, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_ONE, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_ZERO, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_ONE, 12'd0, 4'd0, 64'd0);
               queue_word(KIND_REPLY, scp_pkg::CHAR_CR, 12'd0, 4'd0, 64'd0);
            end else begin
               queue_word(KIND_REPLY, scp_pkg::CHAR_BEL, 12'd0, 4'd0, 64'd0);
            end
            line_len = 0;
            foreach (line_buf[i]) line_buf[i] = 8'h00;
         end
      end else if (line_len < LINE_CAPACITY - 1) begin
         line_buf[line_len] = ch;
         line_len++;
      end
      if (new_words.size() > 0) new_words[new_words.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [7:0] rand_hex();
      logic [3:0] d;
      d = 4'($urandom_range(15));
      if (d < 4'd10) return 8'("0" + d);
      return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
   endfunction

   task automatic report_err(string msg);
      err_count++;
      if (err_count <= 40) $display("mismatch: %s", msg);
   endtask

   task automatic send_char(logic [7:0] ch, logic [7:0] ef, logic fixed, logic [7:0] want);
      rsp_word_type w;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= ch;
      req_error_flags <= ef;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_char(ch, ef);
      if (fixed) begin
         w = '{kind: KIND_REPLY, reply: want, id: 12'd0, len: 4'd0, data: 64'd0, last: 1'b1};
         pending_words.push_back(w);
      end else begin
         foreach (new_words[i]) pending_words.push_back(new_words[i]);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want_w;
      if (!reset) begin
         rsp_ready <= calm || ($urandom_range(99) >= 11);
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               report_err($sformatf("word with nothing pending: kind %0d reply %02h id %03h",
                                    rsp_result_kind, rsp_reply_byte, rsp_frame_id));
            end else begin
               want_w = pending_words.pop_front();
               if (rsp_result_kind !== want_w.kind || rsp_reply_byte !== want_w.reply ||
                   rsp_frame_id !== want_w.id || rsp_frame_length !== want_w.len ||
                   rsp_frame_data !== want_w.data || rsp_last_of_run !== want_w.last) begin
                  report_err($sformatf(
                     "got %0d/%02h/%03h/%0d/%016h/%0d want %0d/%02h/%03h/%0d/%016h/%0d",
                     rsp_result_kind, rsp_reply_byte, rsp_frame_id, rsp_frame_length,
                     rsp_frame_data, rsp_last_of_run, want_w.kind, want_w.reply, want_w.id,
                     want_w.len, want_w.data, want_w.last));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_slcan_command_parser: done, errors");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] line_q [$];
      int         rand_sent;
      int         pick;
      int         digits;
      line_len  = 0;
      chan_open = 1'b0;
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      rand_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i]) begin
         send_char(DIR_ROWS[i].ch, DIR_ROWS[i].ef, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
      end

      while (rand_sent < RANDOM_ITEMS) begin
         calm <= (rand_sent >= 120 && rand_sent < 200);
         line_q.delete();
         pick = $urandom_range(99);
         if (pick < 30) begin
            line_q.push_back(scp_pkg::CHAR_T);
            repeat (3) begin
               line_q.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : rand_hex());
            end
            line_q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
                             8'(scp_pkg::CHAR_ZERO + $urandom_range(8)));
            digits = ($urandom_range(9) == 0) ? $urandom_range(16) : 16;
            repeat (digits) begin
               line_q.push_back(($urandom_range(24) == 0) ? 8'($urandom_range(255)) : rand_hex());
            end
         end else if (pick < 40) begin
            line_q.push_back(scp_pkg::CHAR_O);
         end else if (pick < 45) begin
            line_q.push_back(scp_pkg::CHAR_C);
         end else if (pick < 52) begin
            line_q.push_back(scp_pkg::CHAR_S);
         end else if (pick < 60) begin
            line_q.push_back(scp_pkg::CHAR_F);
         end else if (pick < 66) begin
            line_q.push_back(scp_pkg::CHAR_V);
         end else if (pick < 76) begin
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
         end else if (pick < 82) begin
            line_q.push_back(scp_pkg::CHAR_T);
            repeat ($urandom_range(31, 40)) line_q.push_back(rand_hex());
         end else if (pick >= 88) begin
            line_q.push_back(CMD_CHARS[$urandom_range(5)]);
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(19) != 0) begin
            line_q.push_back($urandom_range(1) ? scp_pkg::CHAR_CR : scp_pkg::CHAR_LF);
         end
         foreach (line_q[i]) begin
            send_char(line_q[i], 8'($urandom_range(255)), 1'b0, 8'h00);
            rand_sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_slcan_command_parser: done, clean");
      end else begin
         $display("tb_slcan_command_parser: done, errors");
      end
      $finish;
   end

endmodule
